>>> sv/sjk_pkg.sv
// ----------------------------------------------------------------------------
// sjk_pkg
// Types, tables and helper functions for the Shift_JIS half-width kana core.
// ----------------------------------------------------------------------------
package sjk_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [7:0] LeadKana  = 8'h83;
  localparam logic [7:0] LeadPunct = 8'h81;
  localparam logic [7:0] KanaLo    = 8'h40;
  localparam logic [7:0] KanaHi    = 8'h96;
  localparam logic [7:0] PunctLo   = 8'h41;
  localparam logic [7:0] PunctHi   = 8'h4b;
  localparam logic [7:0] TrailOpen = 8'h75;
  localparam logic [7:0] TrailClose = 8'h76;
  localparam logic [7:0] TrailDash = 8'h5b;
  localparam logic [7:0] HalfOpen  = 8'ha2;
  localparam logic [7:0] HalfClose = 8'ha3;
  localparam logic [7:0] HalfDash  = 8'h2d;

  localparam logic [15:0] KanaMap [87] = '{
    16'ha700, 16'hb100, 16'ha800, 16'hb200, 16'ha900, 16'hb300, 16'haa00, 16'hb400,
    16'hab00, 16'hb500, 16'hb600, 16'hb6de, 16'hb700, 16'hb7de, 16'hb800, 16'hb8de,
    16'hb900, 16'hb9de, 16'hba00, 16'hbade, 16'hbb00, 16'hbbde, 16'hbc00, 16'hbcde,
    16'hbd00, 16'hbdde, 16'hbe00, 16'hbede, 16'hbf00, 16'hbfde, 16'hc000, 16'hc0de,
    16'hc100, 16'hc1de, 16'haf00, 16'hc200, 16'hc2de, 16'hc300, 16'hc3de, 16'hc400,
    16'hc4de, 16'hc500, 16'hc600, 16'hc700, 16'hc800, 16'hc900, 16'hca00, 16'hcade,
    16'hcadf, 16'hcb00, 16'hcbde, 16'hcbdf, 16'hcc00, 16'hccde, 16'hccdf, 16'hcd00,
    16'hcdde, 16'hcddf, 16'hce00, 16'hcede, 16'hcedf, 16'hcf00, 16'hd000, 16'h0000,
    16'hd100, 16'hd200, 16'hd300, 16'hac00, 16'hd400, 16'had00, 16'hd500, 16'hae00,
    16'hd600, 16'hd700, 16'hd800, 16'hd900, 16'hda00, 16'hdb00, 16'h838e, 16'hdc00,
    16'h8390, 16'h8391, 16'ha600, 16'hdd00, 16'hb3de, 16'h8395, 16'h8396
  };

  localparam logic [7:0] PunctMap [11] = '{
    8'ha4, 8'ha1, 8'h2c, 8'h2e, 8'ha5, 8'h3a, 8'h3b, 8'h3f, 8'h21, 8'hde, 8'hdf
  };

  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } pair_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } ent_t;

  typedef struct packed {
    logic            ready;
    logic [CntW-1:0] level;
  } fifo_sts_t;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
  endfunction

  function automatic pair_t map_pair(input logic [7:0] lead, input logic [7:0] trail);
    pair_t       p;
    logic [15:0] e;
    logic [7:0]  kofs;
    logic [7:0]  pofs;
    p    = '{two: 1'b1, b0: lead, b1: trail};
    kofs = trail - KanaLo;
    pofs = trail - PunctLo;
    e    = '0;
    if (lead == LeadKana && trail >= KanaLo && trail <= KanaHi) begin
      e = KanaMap[kofs[6:0]];
      if (e != 16'h0000) begin
        p.b0  = e[15:8];
        p.b1  = e[7:0];
        p.two = (e[7:0] != 8'h00);
      end
    end else if (lead == LeadPunct) begin
      if (trail >= PunctLo && trail <= PunctHi) begin
        p.b0  = PunctMap[pofs[3:0]];
        p.two = 1'b0;
      end else if (trail == TrailOpen) begin
        p.b0  = HalfOpen;
        p.two = 1'b0;
      end else if (trail == TrailClose) begin
        p.b0  = HalfClose;
        p.two = 1'b0;
      end else if (trail == TrailDash) begin
        p.b0  = HalfDash;
        p.two = 1'b0;
      end
    end
    map_pair = p;
  endfunction

endpackage

>>> sv/sjk_in_if.sv
// ----------------------------------------------------------------------------
// sjk_in_if
// Input byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sjk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> sv/sjk_out_if.sv
// ----------------------------------------------------------------------------
// sjk_out_if
// Output byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sjk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       stream_end;

  modport source (output valid, output out_byte, output run_end, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input stream_end,
                  output ready);
endinterface

>>> sv/sjk_mapper.sv
// ----------------------------------------------------------------------------
// sjk_mapper
// Holds a pending lead byte and maps each accepted beat to zero, one or two
// result bytes.
// ----------------------------------------------------------------------------
module sjk_mapper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          accept_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output sjk_pkg::res_t res_o,
  output logic          pending_o
);
  import sjk_pkg::*;

  logic       pend_d, pend_q;
  logic [7:0] held_d, held_q;
  pair_t      pr;

  always_comb begin
    res_o  = '0;
    pend_d = pend_q;
    held_d = held_q;
    pr     = '{two: 1'b1, b0: held_q, b1: byte_i};
    if (accept_i) begin
      res_o.last = last_i;
      if (pend_q) begin
        if (enable_i) begin
          pr = map_pair(held_q, byte_i);
        end
        res_o.cnt = pr.two ? 2'd2 : 2'd1;
        res_o.b0  = pr.b0;
        res_o.b1  = pr.b1;
        pend_d    = 1'b0;
        held_d    = '0;
      end else if (enable_i && is_lead(byte_i) && !last_i) begin
        pend_d = 1'b1;
        held_d = byte_i;
      end else begin
        res_o.cnt = 2'd1;
        res_o.b0  = byte_i;
      end
      if (last_i) begin
        pend_d = 1'b0;
        held_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      held_q <= '0;
    end else begin
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

  assign pending_o = pend_q;

endmodule

>>> sv/sjk_ofifo.sv
// ----------------------------------------------------------------------------
// sjk_ofifo
// Small result queue: takes up to two bytes per cycle, sends one per cycle while out_o.ready is high.
// ----------------------------------------------------------------------------
module sjk_ofifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sjk_pkg::res_t     res_i,
  output sjk_pkg::fifo_sts_t sts_o,
  sjk_out_if.source         out_o
);
  import sjk_pkg::*;

  ent_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [PtrW-1:0] wr_ptr_nx;
  logic            pop;

  assign pop       = out_o.valid && out_o.ready;
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(res_i.cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(res_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_i.cnt == 2'd1) begin
      mem_q[wr_ptr_q] <= '{data: res_i.b0, run_end: 1'b1, stream_end: res_i.last};
    end else if (res_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q]  <= '{data: res_i.b0, run_end: 1'b0, stream_end: 1'b0};
      mem_q[wr_ptr_nx] <= '{data: res_i.b1, run_end: 1'b1, stream_end: res_i.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.out_byte   = mem_q[rd_ptr_q].data;
  assign out_o.run_end    = mem_q[rd_ptr_q].run_end;
  assign out_o.stream_end = mem_q[rd_ptr_q].stream_end;

  assign sts_o.ready = (cnt_q <= CntW'(FifoDepth - 2));
  assign sts_o.level = cnt_q;

endmodule

>>> sv/sjis_fullwidth_to_halfwidth_kana_core.sv
// ----------------------------------------------------------------------------
// sjis_fullwidth_to_halfwidth_kana_core
// Converts full-width Shift_JIS katakana and punctuation to half-width bytes.
//
// Bytes enter on in_i, one per beat, with in_last marking the end of a text.
// Converted bytes leave on out_o, one per beat; run_end flags the last byte
// caused by an input beat and stream_end the final byte of the text.
// With conversion on, a non-last lead byte waits one beat and makes no output.
// The result bytes of an accepted input beat are registered in the result
// queue and reach out_o behind any bytes that are still waiting there.
// Throughput is one input beat per cycle; the output side sends one byte per
// cycle from a four-entry result queue, and in_i.ready is low while that queue
// holds more than two bytes.
// A stalled receiver fills the queue and then back-pressures in_i.
// Reset empties the queue, drops any held lead byte and clears
// convert_enable, so every byte passes through until it is written.
// ----------------------------------------------------------------------------
module sjis_fullwidth_to_halfwidth_kana_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  sjk_in_if.sink    in_i,
  sjk_out_if.source out_o
);
  import sjk_pkg::*;

  logic      enable_q;
  logic      accept;
  logic      pending;
  res_t      res;
  fifo_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = sts.ready;
  assign accept     = in_i.valid && in_i.ready;

  sjk_mapper u_mapper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .enable_i  (enable_q),
    .accept_i  (accept),
    .byte_i    (in_i.in_byte),
    .last_i    (in_i.in_last),
    .res_o     (res),
    .pending_o (pending)
  );

  sjk_ofifo u_ofifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.level <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_last_clears_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.in_last) |=> !pending)
    else $error("lead byte still held after end of stream");

  a_stream_end_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stream_end) |-> out_o.run_end)
    else $error("stream_end without run_end");

  a_hold_no_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pending && $rose(pending) == 1'b0 && res.cnt == 2'd0) |=> pending)
    else $error("accepted beat produced neither output nor hold");

endmodule

>>> tb/tb_sjis_fullwidth_to_halfwidth_kana_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sjis_fullwidth_to_halfwidth_kana_core
// Self-checking bench for the Shift_JIS full-width to half-width kana core.
//
// Directed tests cover pass-through at reset, katakana and punctuation pairs,
// lone lead bytes at the end of a text and a lead byte held across a disable.
// Random text follows with convert_enable on, off and on again. A scoreboard
// predicts the output beats of every accepted input beat and compares each
// output beat with the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sjis_fullwidth_to_halfwidth_kana_core;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ShownErrs  = 10;

  localparam logic [7:0] KanaLead   = 8'h83;
  localparam logic [7:0] PunctLead  = 8'h81;
  localparam logic [7:0] KanaFirst  = 8'h40;
  localparam logic [7:0] KanaLast   = 8'h96;
  localparam logic [7:0] PunctFirst = 8'h41;
  localparam logic [7:0] PunctLast  = 8'h4b;
  localparam logic [7:0] OpenQuote  = 8'h75;
  localparam logic [7:0] CloseQuote = 8'h76;
  localparam logic [7:0] LongVowel  = 8'h5b;

  localparam logic [15:0] KanaHalf [87] = '{
    16'ha700, 16'hb100, 16'ha800, 16'hb200, 16'ha900, 16'hb300, 16'haa00, 16'hb400,
    16'hab00, 16'hb500, 16'hb600, 16'hb6de, 16'hb700, 16'hb7de, 16'hb800, 16'hb8de,
    16'hb900, 16'hb9de, 16'hba00, 16'hbade, 16'hbb00, 16'hbbde, 16'hbc00, 16'hbcde,
    16'hbd00, 16'hbdde, 16'hbe00, 16'hbede, 16'hbf00, 16'hbfde, 16'hc000, 16'hc0de,
    16'hc100, 16'hc1de, 16'haf00, 16'hc200, 16'hc2de, 16'hc300, 16'hc3de, 16'hc400,
    16'hc4de, 16'hc500, 16'hc600, 16'hc700, 16'hc800, 16'hc900, 16'hca00, 16'hcade,
    16'hcadf, 16'hcb00, 16'hcbde, 16'hcbdf, 16'hcc00, 16'hccde, 16'hccdf, 16'hcd00,
    16'hcdde, 16'hcddf, 16'hce00, 16'hcede, 16'hcedf, 16'hcf00, 16'hd000, 16'h0000,
    16'hd100, 16'hd200, 16'hd300, 16'hac00, 16'hd400, 16'had00, 16'hd500, 16'hae00,
    16'hd600, 16'hd700, 16'hd800, 16'hd900, 16'hda00, 16'hdb00, 16'h838e, 16'hdc00,
    16'h8390, 16'h8391, 16'ha600, 16'hdd00, 16'hb3de, 16'h8395, 16'h8396
  };

  localparam logic [7:0] PunctHalf [11] = '{
    8'ha4, 8'ha1, 8'h2c, 8'h2e, 8'ha5, 8'h3a, 8'h3b, 8'h3f, 8'h21, 8'hde, 8'hdf
  };

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } text_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  sjk_in_if  in_if ();
  sjk_out_if out_if ();

  sjis_fullwidth_to_halfwidth_kana_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  text_beat_t  half_text_q [$];
  text_beat_t  oldest_beat;
  logic        conv_on;
  logic        lead_held;
  logic [7:0]  lead_byte;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold   = 0;
  bit          tx_burst  = 1'b0;
  bit          rx_burst  = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic is_sjis_lead(input logic [7:0] b);
    return (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
  endfunction

  function automatic int unsigned halfwidth_pair(input logic [7:0] lead,
                                                 input logic [7:0] trail,
                                                 output logic [7:0] r0,
                                                 output logic [7:0] r1);
    logic [15:0] e;
    r0 = lead;
    r1 = trail;
    if (lead == KanaLead && trail >= KanaFirst && trail <= KanaLast) begin
      e = KanaHalf[int'(trail) - int'(KanaFirst)];
      if (e != 16'h0000) begin
        r0 = e[15:8];
        r1 = e[7:0];
        return (r1 != 8'h00) ? 2 : 1;
      end
    end else if (lead == PunctLead) begin
      if (trail >= PunctFirst && trail <= PunctLast) begin
        r0 = PunctHalf[int'(trail) - int'(PunctFirst)];
        return 1;
      end
      case (trail)
        OpenQuote: begin
          r0 = 8'ha2;
          return 1;
        end
        CloseQuote: begin
          r0 = 8'ha3;
          return 1;
        end
        LongVowel: begin
          r0 = 8'h2d;
          return 1;
        end
        default: ;
      endcase
    end
    r0 = lead;
    r1 = trail;
    return 2;
  endfunction

  function automatic void predict_text_byte(input logic [7:0] b, input logic l);
    logic [7:0]  r0;
    logic [7:0]  r1;
    int unsigned cnt;
    cnt = 0;
    r0  = b;
    r1  = 8'h00;
    if (lead_held) begin
      if (conv_on) begin
        cnt = halfwidth_pair(lead_byte, b, r0, r1);
      end else begin
        r0  = lead_byte;
        r1  = b;
        cnt = 2;
      end
      lead_held = 1'b0;
      lead_byte = 8'h00;
    end else if (conv_on && is_sjis_lead(b) && !l) begin
      lead_held = 1'b1;
      lead_byte = b;
    end else begin
      cnt = 1;
    end
    if (l) begin
      lead_held = 1'b0;
      lead_byte = 8'h00;
    end
    if (cnt == 1) begin
      half_text_q.push_back('{data: r0, run_end: 1'b1, stream_end: l});
    end else if (cnt == 2) begin
      half_text_q.push_back('{data: r0, run_end: 1'b0, stream_end: 1'b0});
      half_text_q.push_back('{data: r1, run_end: 1'b1, stream_end: l});
    end
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= ShownErrs) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_if.valid && in_if.ready) predict_text_byte(in_if.in_byte, in_if.in_last);
      if (out_if.valid && out_if.ready) begin
        if (half_text_q.size() == 0) begin
          note_error($sformatf("unexpected beat byte %02h run_end %0b stream_end %0b",
                               out_if.out_byte, out_if.run_end, out_if.stream_end));
        end else begin
          oldest_beat = half_text_q.pop_front();
          if (out_if.out_byte !== oldest_beat.data ||
              out_if.run_end !== oldest_beat.run_end ||
              out_if.stream_end !== oldest_beat.stream_end) begin
            note_error($sformatf({"beat mismatch: expected %02h/%0b/%0b, ",
                                  "got %02h/%0b/%0b"},
                                 oldest_beat.data, oldest_beat.run_end,
                                 oldest_beat.stream_end, out_if.out_byte,
                                 out_if.run_end, out_if.stream_end));
          end
        end
      end
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (!rx_burst && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        rx_hold = idle_cycles();
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned idle;
    idle = tx_burst ? 0 : idle_cycles();
    if (idle != 0) begin
      in_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (half_text_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_convert(input logic en);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    conv_on = en;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_pass_through();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(KanaLead, 1'b0);
    send_byte(PunctLead, 1'b1);
  endtask

  task automatic test_kana_pairs();
    send_byte(KanaLead, 1'b0);
    send_byte(KanaFirst, 1'b0);
    send_byte(KanaLead, 1'b0);
    send_byte(KanaLast, 1'b0);
    send_byte(KanaLead, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(KanaLead, 1'b0);
    send_byte(8'h4b, 1'b0);
  endtask

  task automatic test_punct_pairs();
    send_byte(PunctLead, 1'b0);
    send_byte(PunctFirst, 1'b0);
    send_byte(PunctLead, 1'b0);
    send_byte(PunctLast, 1'b0);
    send_byte(PunctLead, 1'b0);
    send_byte(OpenQuote, 1'b0);
    send_byte(PunctLead, 1'b0);
    send_byte(LongVowel, 1'b0);
  endtask

  // A lead byte that ends the text is sent alone; a held lead takes any trail.
  task automatic test_lone_lead();
    send_byte(8'hfc, 1'b1);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_disable_held();
    wait_drained();
    set_convert(1'b1);
    send_byte(8'he0, 1'b0);
    wait_drained();
    set_convert(1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_random_text(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    logic [7:0]  lead;
    logic [7:0]  trail;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 59) == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        if (kind < 45) begin
          lead  = KanaLead;
          trail = ($urandom_range(0, 99) < 85) ?
                  8'($urandom_range(KanaFirst, KanaLast)) : 8'($urandom_range(0, 255));
        end else if (kind < 65) begin
          lead = PunctLead;
          case ($urandom_range(0, 4))
            0: trail = 8'($urandom_range(PunctFirst, PunctLast));
            1: trail = LongVowel;
            2: trail = OpenQuote;
            3: trail = CloseQuote;
            default: trail = 8'($urandom_range(0, 255));
          endcase
        end else begin
          lead  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h81, 8'h9f)) :
                                               8'($urandom_range(8'he0, 8'hfc));
          trail = 8'($urandom_range(0, 255));
        end
        send_byte(lead, $urandom_range(0, 19) == 0);
        send_byte(trail, $urandom_range(0, 19) == 0);
        sent += 2;
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        sent += 1;
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    conv_on       = 1'b0;
    lead_held     = 1'b0;
    lead_byte     = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_pass_through();
    wait_drained();
    set_convert(1'b1);
    test_kana_pairs();
    test_punct_pairs();
    test_lone_lead();
    test_disable_held();
    wait_drained();
    set_convert(1'b1);
    test_random_text(800);
    wait_drained();
    set_convert(1'b0);
    test_random_text(350);
    wait_drained();
    set_convert(1'b1);
    test_random_text(700);
    wait_drained();

    if (err_cnt == 0 && half_text_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sjk_pkg.sv
sv/sjk_in_if.sv
sv/sjk_out_if.sv
sv/sjk_mapper.sv
sv/sjk_ofifo.sv
sv/sjis_fullwidth_to_halfwidth_kana_core.sv
tb/tb_sjis_fullwidth_to_halfwidth_kana_core.sv
